### design/lmn_pkg.sv
`default_nettype none
package lmn_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MAX_GRID_DIM = 4096;

  localparam int CNT_W  = 13;
  localparam int IDX_W  = 12;
  localparam int EXT_W  = FRAC_BITS + 1;
  localparam int SPAN_W = 12;
  localparam int NUM_W  = SPAN_W;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int DVD_W  = EXT_W + NUM_W;
  localparam int DIR_W  = FRAC_BITS + 2;
  localparam int SQ_W   = 2 * QUO_W;
  localparam int RSQ_W  = SQ_W + 1;
  localparam int RAD_W  = 2 * QUO_W;
  localparam int REM_W  = QUO_W + 3;

  localparam logic [EXT_W-1:0] UNIT_VAL = EXT_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_GRID_DIM);
  localparam logic [RSQ_W-1:0] ONE_SQ   = RSQ_W'(1) << (2 * FRAC_BITS);

  typedef enum logic [1:0] {
    CFG_COLS    = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_L_EXTENT = 2'd2,
    CFG_M_EXTENT = 2'd3
  } cfg_idx_e;

  // Per-point data that rides alongside the divider row
  typedef struct packed {
    logic             in_range;
    logic [EXT_W-1:0] l_ext;
    logic             l_single;
    logic             l_below;
    logic [EXT_W-1:0] m_ext;
    logic             m_single;
    logic             m_below;
  } side_t;

  // Per-point data that rides alongside the root row
  typedef struct packed {
    logic             ok;
    logic [DIR_W-1:0] dir_l;
    logic [DIR_W-1:0] dir_m;
  } post_t;

endpackage
`default_nettype wire

### design/lmn_div_cell.sv
`default_nettype none
// One restoring-division step: one quotient bit per cell.
module lmn_div_cell (
  input  logic                       clk_i,
  input  logic [lmn_pkg::SPAN_W-1:0] span_i,
  input  logic [lmn_pkg::SPAN_W-1:0] rem_i,
  input  logic [lmn_pkg::QUO_W-1:0]  dvd_i,
  input  logic [lmn_pkg::QUO_W-1:0]  quo_i,
  output logic [lmn_pkg::SPAN_W-1:0] rem_o,
  output logic [lmn_pkg::QUO_W-1:0]  dvd_o,
  output logic [lmn_pkg::QUO_W-1:0]  quo_o
);
  import lmn_pkg::*;

  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   diff;
  logic              ge;
  logic [SPAN_W-1:0] rem_d, rem_q;
  logic [QUO_W-1:0]  dvd_d, dvd_q, quo_d, quo_q;

  always_comb begin
    trial = {rem_i, dvd_i[QUO_W-1]};
    diff  = trial - {1'b0, span_i};
    ge    = trial >= {1'b0, span_i};
    rem_d = ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
    dvd_d = {dvd_i[QUO_W-2:0], 1'b0};
    quo_d = {quo_i[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign rem_o = rem_q;
  assign dvd_o = dvd_q;
  assign quo_o = quo_q;
endmodule
`default_nettype wire

### design/lmn_sqrt_cell.sv
`default_nettype none
// One digit-by-digit square root step: one root bit per cell.
module lmn_sqrt_cell (
  input  logic                      clk_i,
  input  logic [lmn_pkg::REM_W-1:0] rem_i,
  input  logic [lmn_pkg::RAD_W-1:0] rad_i,
  input  logic [lmn_pkg::QUO_W-1:0] root_i,
  output logic [lmn_pkg::REM_W-1:0] rem_o,
  output logic [lmn_pkg::RAD_W-1:0] rad_o,
  output logic [lmn_pkg::QUO_W-1:0] root_o
);
  import lmn_pkg::*;

  logic [REM_W-1:0] cur;
  logic [REM_W-1:0] trial;
  logic             ge;
  logic [REM_W-1:0] rem_d, rem_q;
  logic [RAD_W-1:0] rad_d, rad_q;
  logic [QUO_W-1:0] root_d, root_q;

  always_comb begin
    cur    = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
    trial  = REM_W'({root_i, 2'b01});
    ge     = cur >= trial;
    rem_d  = ge ? cur - trial : cur;
    rad_d  = {rad_i[RAD_W-3:0], 2'b00};
    root_d = {root_i[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    rad_q  <= rad_d;
    root_q <= root_d;
  end

  assign rem_o  = rem_q;
  assign rad_o  = rad_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

### design/image_lmn_grid_point.sv
`default_nettype none
// Direction cosine grid point generator. Takes one (col, row) index pair per
// clock and returns l, m and n = sqrt(1 - l^2 - m^2) in Q1.16, or zeros with
// point_valid low outside the grid or the unit circle. busy is never raised:
// a new point is taken every cycle. Each result is shown for exactly one
// cycle under result_valid_o; the receiver must take it then. The pipeline
// is two rows of 17 cells, one for the division by (count - 1) and one for
// the square root, plus five stages of setup, multiply, squaring, radius
// check and output. Configuration writes are accepted at any time but must
// only be issued with no point in flight.
module image_lmn_grid_point (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [lmn_pkg::IDX_W-1:0] col_index_i,
  input  logic [lmn_pkg::IDX_W-1:0] row_index_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [lmn_pkg::EXT_W-1:0] cfg_data_i,
  output logic                      result_valid_o,
  output logic [lmn_pkg::DIR_W-1:0] dir_l_o,
  output logic [lmn_pkg::DIR_W-1:0] dir_m_o,
  output logic [lmn_pkg::QUO_W-1:0] dir_n_o,
  output logic                      point_valid_o
);
  import lmn_pkg::*;

  localparam int NCELL = QUO_W;
  localparam int LAT   = 2 * NCELL + 5;

  logic [CNT_W-1:0] cols_q, rows_q;
  logic [EXT_W-1:0] lext_q, mext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CNT_W'(256);
      rows_q <= CNT_W'(256);
      lext_q <= UNIT_VAL;
      mext_q <= UNIT_VAL;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COLS:     cols_q <= cfg_data_i[CNT_W-1:0];
        CFG_ROWS:     rows_q <= cfg_data_i[CNT_W-1:0];
        CFG_L_EXTENT: lext_q <= cfg_data_i;
        CFG_M_EXTENT: mext_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Clamped configuration
  logic [CNT_W-1:0]  nl, nm, nl_m1, nm_m1;
  logic [SPAN_W-1:0] l_span, m_span;
  logic [EXT_W-1:0]  l_ext, m_ext;

  always_comb begin
    nl     = (cols_q > MAX_CNT) ? MAX_CNT : cols_q;
    nm     = (rows_q > MAX_CNT) ? MAX_CNT : rows_q;
    nl_m1  = nl - CNT_W'(1);
    nm_m1  = nm - CNT_W'(1);
    l_span = nl_m1[SPAN_W-1:0];
    m_span = nm_m1[SPAN_W-1:0];
    l_ext  = (lext_q > UNIT_VAL) ? UNIT_VAL : lext_q;
    m_ext  = (mext_q > UNIT_VAL) ? UNIT_VAL : mext_q;
  end

  // Stage 0: distance from axis center in half steps
  logic [CNT_W-1:0] l_twice, m_twice, l_diff, m_diff;
  side_t            side0_d, side0_q;
  logic [NUM_W-1:0] lnum0_q, mnum0_q;

  always_comb begin
    l_twice          = {col_index_i, 1'b0};
    m_twice          = {row_index_i, 1'b0};
    side0_d.in_range = ({1'b0, col_index_i} < nl) && ({1'b0, row_index_i} < nm);
    side0_d.l_ext    = l_ext;
    side0_d.m_ext    = m_ext;
    side0_d.l_single = nl <= CNT_W'(1);
    side0_d.m_single = nm <= CNT_W'(1);
    side0_d.l_below  = l_twice < {1'b0, l_span};
    side0_d.m_below  = m_twice < {1'b0, m_span};
    l_diff = side0_d.l_below ? {1'b0, l_span} - l_twice : l_twice - {1'b0, l_span};
    m_diff = side0_d.m_below ? {1'b0, m_span} - m_twice : m_twice - {1'b0, m_span};
  end

  always_ff @(posedge clk_i) begin
    side0_q <= side0_d;
    lnum0_q <= l_diff[NUM_W-1:0];
    mnum0_q <= m_diff[NUM_W-1:0];
  end

  // Stage 1: rounded dividend ext * num + span / 2
  logic [DVD_W-1:0] ldvd_q, mdvd_q;
  side_t            side_q [NCELL+1];

  always_ff @(posedge clk_i) begin
    ldvd_q <= DVD_W'(side0_q.l_ext * lnum0_q) + DVD_W'(l_span >> 1);
    mdvd_q <= DVD_W'(side0_q.m_ext * mnum0_q) + DVD_W'(m_span >> 1);
    side_q[0] <= side0_q;
    for (int k = 0; k < NCELL; k++) begin
      side_q[k+1] <= side_q[k];
    end
  end

  // Divider rows
  logic [SPAN_W-1:0] lrem [NCELL+1];
  logic [SPAN_W-1:0] mrem [NCELL+1];
  logic [QUO_W-1:0]  ldv  [NCELL+1];
  logic [QUO_W-1:0]  mdv  [NCELL+1];
  logic [QUO_W-1:0]  lquo [NCELL+1];
  logic [QUO_W-1:0]  mquo [NCELL+1];

  assign lrem[0] = ldvd_q[DVD_W-1 -: SPAN_W];
  assign mrem[0] = mdvd_q[DVD_W-1 -: SPAN_W];
  assign ldv[0]  = ldvd_q[QUO_W-1:0];
  assign mdv[0]  = mdvd_q[QUO_W-1:0];
  assign lquo[0] = '0;
  assign mquo[0] = '0;

  for (genvar g = 0; g < NCELL; g++) begin : g_div
    lmn_div_cell u_l (
      .clk_i (clk_i), .span_i(l_span), .rem_i(lrem[g]), .dvd_i(ldv[g]),
      .quo_i (lquo[g]), .rem_o(lrem[g+1]), .dvd_o(ldv[g+1]), .quo_o(lquo[g+1])
    );
    lmn_div_cell u_m (
      .clk_i (clk_i), .span_i(m_span), .rem_i(mrem[g]), .dvd_i(mdv[g]),
      .quo_i (mquo[g]), .rem_o(mrem[g+1]), .dvd_o(mdv[g+1]), .quo_o(mquo[g+1])
    );
  end

  // Squares and signs
  side_t            sd;
  logic [QUO_W-1:0] lmag, mmag;
  logic             lneg, mneg;
  logic [SQ_W-1:0]  lsq_q, msq_q;
  post_t            sqp_q;

  always_comb begin
    sd   = side_q[NCELL];
    lmag = sd.l_single ? sd.l_ext : lquo[NCELL];
    mmag = sd.m_single ? sd.m_ext : mquo[NCELL];
    lneg = !sd.l_single && (lmag != '0) && !sd.l_below;
    mneg = sd.m_single ? (sd.m_ext != '0) : ((mmag != '0) && sd.m_below);
  end

  always_ff @(posedge clk_i) begin
    lsq_q        <= lmag * lmag;
    msq_q        <= mmag * mmag;
    sqp_q.ok     <= sd.in_range;
    sqp_q.dir_l  <= lneg ? DIR_W'(0) - DIR_W'(lmag) : DIR_W'(lmag);
    sqp_q.dir_m  <= mneg ? DIR_W'(0) - DIR_W'(mmag) : DIR_W'(mmag);
  end

  // Radius check and radicand
  logic [RSQ_W-1:0] rsq, rad_full;
  logic [RAD_W-1:0] rad_q;
  post_t            post_q [NCELL+1];

  always_comb begin
    rsq      = RSQ_W'(lsq_q) + RSQ_W'(msq_q);
    rad_full = ONE_SQ - rsq;
  end

  always_ff @(posedge clk_i) begin
    rad_q           <= rad_full[RAD_W-1:0];
    post_q[0].ok    <= sqp_q.ok && (rsq <= ONE_SQ);
    post_q[0].dir_l <= sqp_q.dir_l;
    post_q[0].dir_m <= sqp_q.dir_m;
    for (int k = 0; k < NCELL; k++) begin
      post_q[k+1] <= post_q[k];
    end
  end

  // Root row
  logic [REM_W-1:0] srem  [NCELL+1];
  logic [RAD_W-1:0] srad  [NCELL+1];
  logic [QUO_W-1:0] sroot [NCELL+1];

  assign srem[0]  = '0;
  assign srad[0]  = rad_q;
  assign sroot[0] = '0;

  for (genvar g = 0; g < NCELL; g++) begin : g_sqrt
    lmn_sqrt_cell u_s (
      .clk_i (clk_i), .rem_i(srem[g]), .rad_i(srad[g]), .root_i(sroot[g]),
      .rem_o (srem[g+1]), .rad_o(srad[g+1]), .root_o(sroot[g+1])
    );
  end

  // Output register
  post_t            pf;
  logic [QUO_W-1:0] n_round;
  logic [LAT-1:0]   vld_q;
  logic [DIR_W-1:0] dir_l_q, dir_m_q;
  logic [QUO_W-1:0] dir_n_q;
  logic             pv_q;

  always_comb begin
    pf      = post_q[NCELL];
    n_round = sroot[NCELL] + QUO_W'(srem[NCELL] > REM_W'(sroot[NCELL]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q    <= pf.ok;
    dir_l_q <= pf.ok ? pf.dir_l : '0;
    dir_m_q <= pf.ok ? pf.dir_m : '0;
    dir_n_q <= pf.ok ? n_round : '0;
  end

  assign result_valid_o = vld_q[LAT-1];
  assign dir_l_o        = dir_l_q;
  assign dir_m_o        = dir_m_q;
  assign dir_n_o        = dir_n_q;
  assign point_valid_o  = pv_q;
endmodule
`default_nettype wire

### bench/image_lmn_grid_point_tb.sv
`timescale 1ns / 100ps
module image_lmn_grid_point_tb;
  import lmn_pkg::*;

  localparam int LATENCY   = 39;
  localparam int WDOG_MAX  = 4000;
  localparam int N_RANDOM  = 1130;

  typedef struct packed {
    logic [DIR_W-1:0] l;
    logic [DIR_W-1:0] m;
    logic [QUO_W-1:0] n;
    logic             ok;
  } lmn_t;

  logic clk_i, rst_ni;
  logic start;
  logic busy;
  logic [IDX_W-1:0] col_index_i, row_index_i;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [EXT_W-1:0] cfg_data_i;
  logic result_valid_o;
  logic [DIR_W-1:0] dir_l_o, dir_m_o;
  logic [QUO_W-1:0] dir_n_o;
  logic point_valid_o;

  image_lmn_grid_point DUT (.*);

  // shadow of the block's registers
  logic [CNT_W-1:0] grid_cols, grid_rows;
  logic [EXT_W-1:0] grid_l_ext, grid_m_ext;

  lmn_t expected_points[$];
  int   mismatches;
  int   points_seen;
  int   valid_seen;
  int   idle_cycles;
  bit   timed_out;
  bit   allow_gaps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned root_rounded(longint unsigned x);
    longint unsigned res, bit_v, v;
    res   = 0;
    bit_v = 64'd1 << 62;
    v     = x;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v   -= res + bit_v;
        res  = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    if (v > res) res += 1;
    return res;
  endfunction

  // signed axis value; rising runs -ext..+ext, else +ext..-ext
  function automatic longint axis_value(longint unsigned ext, longint unsigned cnt,
                                        longint unsigned idx, bit rising);
    longint unsigned span, twice, num, mag;
    bit below, neg;
    if (cnt <= 1) begin
      return rising ? -longint'(ext) : longint'(ext);
    end
    span  = cnt - 1;
    twice = 2 * idx;
    below = twice < span;
    num   = below ? span - twice : twice - span;
    mag   = (ext * num + span / 2) / span;
    neg   = (mag != 0) && (rising ? below : !below);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic lmn_t grid_point(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
    lmn_t r;
    longint unsigned nl, nm, le, me, rsq, one_sq;
    longint lv, mv;
    r  = '0;
    nl = (grid_cols > MAX_GRID_DIM) ? MAX_GRID_DIM : grid_cols;
    nm = (grid_rows > MAX_GRID_DIM) ? MAX_GRID_DIM : grid_rows;
    le = (grid_l_ext > UNIT_VAL) ? UNIT_VAL : grid_l_ext;
    me = (grid_m_ext > UNIT_VAL) ? UNIT_VAL : grid_m_ext;
    if (col >= nl || row >= nm) return r;
    lv = axis_value(le, nl, col, 1'b0);
    mv = axis_value(me, nm, row, 1'b1);
    one_sq = 64'd1 << (2 * FRAC_BITS);
    rsq = lv * lv + mv * mv;
    if (rsq > one_sq) return r;
    r.l  = DIR_W'(lv);
    r.m  = DIR_W'(mv);
    r.n  = QUO_W'(root_rounded(one_sq - rsq));
    r.ok = 1'b1;
    return r;
  endfunction

  // result side: strobe lasts one cycle, taken at the edge ending it
  always @(posedge clk_i) begin
    lmn_t got, want;
    if (rst_ni && result_valid_o) begin
      got = '{dir_l_o, dir_m_o, dir_n_o, point_valid_o};
      points_seen++;
      if (point_valid_o) valid_seen++;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result l=%h m=%h n=%h v=%b",
                                       dir_l_o, dir_m_o, dir_n_o, point_valid_o);
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected l=%h m=%h n=%h v=%b, got l=%h m=%h n=%h v=%b",
                     want.l, want.m, want.n, want.ok, got.l, got.m, got.n, got.ok);
        end
      end
    end
  end

  // watchdog: cycles with no start, result or configuration beat
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WDOG_MAX && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired");
      $display("FAILED: results differ");
      $finish;
    end
  end

  // leaves cfg_valid_i high; the caller drops it after the last beat
  task automatic write_reg(cfg_idx_e idx, logic [EXT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_COLS:     grid_cols  = CNT_W'(data);
      CFG_ROWS:     grid_rows  = CNT_W'(data);
      CFG_L_EXTENT: grid_l_ext = data;
      CFG_M_EXTENT: grid_m_ext = data;
      default: ;
    endcase
  endtask

  task automatic setup_grid(logic [EXT_W-1:0] cols, logic [EXT_W-1:0] rows,
                            logic [EXT_W-1:0] le, logic [EXT_W-1:0] me);
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_L_EXTENT, le);
    write_reg(CFG_M_EXTENT, me);
    cfg_valid_i <= 1'b0;
  endtask

  // one start beat; typed set means "want" is the typed-in answer
  task automatic send_point(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row,
                            bit typed, lmn_t want);
    if (allow_gaps && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start       <= 1'b1;
    col_index_i <= col;
    row_index_i <= row;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_points.push_back(typed ? want : grid_point(col, row));
  endtask

  typedef struct {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    bit               typed;
    lmn_t             want;
  } probe_t;

  localparam lmn_t BAD = '0;
  localparam lmn_t ZENITH = '{18'd0, 18'd0, 17'h10000, 1'b1};

  // reset config: 256x256 grid, extent 1.0
  probe_t probes[14] = '{
    '{12'd0,    12'd0,    1'b1, BAD},                // corner outside circle
    '{12'd255,  12'd255,  1'b1, BAD},
    '{12'd0,    12'd128,  1'b0, BAD},                // l=+1 edge
    '{12'd255,  12'd128,  1'b0, BAD},
    '{12'd128,  12'd0,    1'b0, BAD},
    '{12'd128,  12'd255,  1'b0, BAD},
    '{12'd127,  12'd127,  1'b0, BAD},
    '{12'd128,  12'd128,  1'b0, BAD},
    '{12'd256,  12'd10,   1'b1, BAD},                // col beyond count
    '{12'd10,   12'd256,  1'b1, BAD},
    '{12'd4095, 12'd4095, 1'b1, BAD},
    '{12'd4095, 12'd0,    1'b1, BAD},
    '{12'd0,    12'd4095, 1'b1, BAD},
    '{12'd100,  12'd200,  1'b0, BAD}
  };

  task automatic random_points(int count, int col_lim, int row_lim);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_point(IDX_W'($urandom), IDX_W'($urandom), 1'b0, BAD);
      else
        send_point(IDX_W'($urandom_range(0, col_lim)),
                   IDX_W'($urandom_range(0, row_lim)), 1'b0, BAD);
    end
  endtask

  initial begin
    int phase_items;
    int cols, rows;
    rst_ni      = 1'b0;
    start       = 1'b0;
    col_index_i = '0;
    row_index_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_COLS;
    cfg_data_i  = '0;
    mismatches  = 0;
    points_seen = 0;
    valid_seen  = 0;
    idle_cycles = 0;
    timed_out   = 1'b0;
    allow_gaps  = 1'b1;
    grid_cols   = 13'd256;
    grid_rows   = 13'd256;
    grid_l_ext  = UNIT_VAL;
    grid_m_ext  = UNIT_VAL;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) send_point(probes[i].col, probes[i].row, probes[i].typed,
                                   probes[i].want);
    start <= 1'b0;

    // single point grid at zero extent: zenith
    setup_grid(17'd1, 17'd1, 17'd0, 17'd0);
    send_point(12'd0, 12'd0, 1'b1, ZENITH);
    send_point(12'd1, 12'd0, 1'b1, BAD);
    start <= 1'b0;
    // zero counts: nothing valid; extents above 1.0 saturate
    setup_grid(17'd0, 17'd0, 17'h1FFFF, 17'h1FFFF);
    send_point(12'd0, 12'd0, 1'b1, BAD);
    start <= 1'b0;
    // counts above the maximum saturate
    setup_grid(17'h1FFF, 17'd4097, 17'd46341, 17'd46340);
    send_point(12'd4095, 12'd4095, 1'b0, BAD);
    send_point(12'd2048, 12'd0, 1'b0, BAD);
    send_point(12'd0, 12'd2047, 1'b0, BAD);

    for (int ph = 0; ph < 8; ph++) begin
      start <= 1'b0;
      case (ph)
        0: begin cols = 4096; rows = 4096; end
        1: begin cols = 2;    rows = 3;    end
        default: begin
          cols = (ph % 2) ? $urandom_range(1, 40) : $urandom_range(1, 4096);
          rows = (ph % 3) ? $urandom_range(1, 40) : $urandom_range(1, 4096);
        end
      endcase
      setup_grid(EXT_W'(cols), EXT_W'(rows),
                 (ph == 0) ? UNIT_VAL : EXT_W'($urandom_range(0, 65536)),
                 (ph == 1) ? 17'd0 : EXT_W'($urandom_range(0, 70000)));
      allow_gaps  = (ph < 6);
      phase_items = N_RANDOM / 8;
      random_points(phase_items, cols, rows);
    end
    start <= 1'b0;

    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("%0d points checked (%0d valid), register sweeps over counts and extents",
             points_seen, valid_seen);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
design/lmn_pkg.sv
design/lmn_div_cell.sv
design/lmn_sqrt_cell.sv
design/image_lmn_grid_point.sv
bench/image_lmn_grid_point_tb.sv
